/* rtl/periodic_timer_bank_assert.svh */
// Assertion macros for the timer bank
`ifndef PERIODIC_TIMER_BANK_ASSERT_SVH
`define PERIODIC_TIMER_BANK_ASSERT_SVH

`define PTB_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("ptb check failed");

`define PTB_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("ptb check failed");

`endif

/* rtl/ptb_pkg.sv */
`default_nettype none
package ptb_pkg;
    localparam int SLOTS = 16;
    localparam int SLOT_W = 4;
    localparam int NOW_W = 63;
    localparam int TIME_W = 64;
    localparam int PER_W = 32;

    typedef enum logic [3:0] {
        MODE_TICK = 4'd0, MODE_ADD = 4'd1, MODE_START = 4'd2, MODE_STOP = 4'd3,
        MODE_DELETE = 4'd4, MODE_WAIT = 4'd5, MODE_NOTIFY = 4'd6,
        MODE_CLR_SCENE = 4'd7, MODE_CLR_ALL = 4'd8
    } mode_t;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0, KIND_ADDED = 2'd1, KIND_FULL = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_DIV, ST_WRITE, ST_OUT, ST_ADD_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic [NOW_W-1:0] dividend;
        logic [PER_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic [PER_W-1:0] rem;
    } div_rsp_t;
endpackage
`default_nettype wire

/* rtl/periodic_timer_bank.sv */
// Periodic timer bank: 16 slots of periodic timers.
// Input channel (valid/ready): one word per event - mode, now, name_key,
// scene, interval_ticks. Output channel (out_valid/out_ready): result words
// kind, slot, fired_name, last; last marks the final word of an event.
// Add gives one word; tick gives one word per fired slot in slot order;
// other events give none. An event is worked through one slot per cycle
// while no fired slot or output word holds the scan, so most events hold
// ready low until all 16 slots are scanned, add until its word is taken,
// clear all for its first scan step only. A fired slot runs a 63-step
// bit-serial modulo (none with a zero interval) and holds the scan while
// it runs and while an output word waits. ready is low while an event is
// in work. A stalled receiver holds the block in the output state with
// the word unchanged. Reset clears all valid marks and the sequencer;
// slot contents are undefined until an add writes them.
`default_nettype none
module periodic_timer_bank (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic valid,
    output logic ready,
    input  wire logic [3:0] mode,
    input  wire logic [62:0] now,
    input  wire logic [15:0] name_key,
    input  wire logic [7:0] scene,
    input  wire logic [31:0] interval_ticks,
    output logic out_valid,
    input  wire logic out_ready,
    output logic [1:0] kind,
    output logic [3:0] slot,
    output logic [15:0] fired_name,
    output logic last
);
    localparam int SW = ptb_pkg::SLOT_W;

    ptb_pkg::state_t state_reg, state_next;
    logic [ptb_pkg::SLOTS-1:0] vld_reg, vld_next;
    logic [ptb_pkg::SLOTS-1:0] run_mem, wait_mem;
    logic [15:0] name_mem [ptb_pkg::SLOTS];
    logic [7:0] scene_mem [ptb_pkg::SLOTS];
    logic [31:0] per_mem [ptb_pkg::SLOTS];
    logic [63:0] last_mem [ptb_pkg::SLOTS];

    logic [3:0] mode_reg;
    logic [62:0] now_reg;
    logic [15:0] name_reg;
    logic [7:0] scene_reg;
    logic [31:0] per_reg;
    logic [SW:0] idx_reg, idx_next;
    logic [SW-1:0] ix;
    logic [1:0] kind_reg, kind_next;
    logic [SW-1:0] oslot_reg, oslot_next;
    logic [15:0] oname_reg, oname_next;
    logic olast_reg, olast_next;
    logic pend_reg, pend_next;
    logic [SW-1:0] pslot_reg, pslot_next;
    logic [15:0] pname_reg, pname_next;
    logic any_free;
    logic [SW-1:0] free_ix;
    logic fire, nmatch, smatch, more;
    logic [63:0] diff;
    logic wr_last, wr_run, wr_wait_set, wr_wait_clr, wr_add;
    logic [63:0] wr_last_val;
    ptb_pkg::div_req_t dreq;
    ptb_pkg::div_rsp_t drsp;

    ptb_mod_unit u_mod (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign ix = idx_reg[SW-1:0];
    assign diff = {1'b0, now_reg} - last_mem[ix];
    assign fire = vld_reg[ix] && run_mem[ix] && !wait_mem[ix]
        && ({1'b0, now_reg} > last_mem[ix]) && (diff > {32'd0, per_mem[ix]});
    assign smatch = vld_reg[ix] && scene_mem[ix] == scene_reg;
    assign nmatch = smatch && name_mem[ix] == name_reg;

    always_comb begin
        any_free = 1'b0;
        free_ix = '0;
        for (int i = ptb_pkg::SLOTS - 1; i >= 0; i--) begin
            if (!vld_reg[i]) begin
                any_free = 1'b1;
                free_ix = SW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ptb_pkg::ST_IDLE;
            vld_reg <= '0;
            pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            vld_reg <= vld_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk) begin
        idx_reg <= idx_next;
        kind_reg <= kind_next;
        oslot_reg <= oslot_next;
        oname_reg <= oname_next;
        olast_reg <= olast_next;
        pslot_reg <= pslot_next;
        pname_reg <= pname_next;
        if (valid && ready) begin
            mode_reg <= mode;
            now_reg <= now;
            name_reg <= name_key;
            scene_reg <= scene;
            per_reg <= interval_ticks;
        end
        if (wr_add) begin
            name_mem[free_ix] <= name_reg;
            scene_mem[free_ix] <= scene_reg;
            per_mem[free_ix] <= per_reg;
            last_mem[free_ix] <= {1'b0, now_reg};
            run_mem[free_ix] <= 1'b1;
            wait_mem[free_ix] <= 1'b0;
        end
        if (wr_last) last_mem[ix] <= wr_last_val;
        if (wr_run) run_mem[ix] <= (mode_reg == ptb_pkg::MODE_START);
        if (wr_wait_set) wait_mem[ix] <= 1'b1;
        if (wr_wait_clr) wait_mem[ix] <= 1'b0;
    end

    always_comb begin
        state_next = state_reg;
        vld_next = vld_reg;
        idx_next = idx_reg;
        kind_next = kind_reg;
        oslot_next = oslot_reg;
        oname_next = oname_reg;
        olast_next = olast_reg;
        pend_next = pend_reg;
        pslot_next = pslot_reg;
        pname_next = pname_reg;
        wr_last = 1'b0;
        wr_last_val = {1'b0, now_reg};
        wr_run = 1'b0;
        wr_wait_set = 1'b0;
        wr_wait_clr = 1'b0;
        wr_add = 1'b0;
        dreq.start = 1'b0;
        dreq.dividend = now_reg;
        dreq.divisor = per_mem[ix];
        more = idx_reg != (SW+1)'(ptb_pkg::SLOTS - 1);
        ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ptb_pkg::ST_IDLE: begin
                ready = 1'b1;
                if (valid) begin
                    idx_next = '0;
                    pend_next = 1'b0;
                    state_next = ptb_pkg::ST_SCAN;
                end
            end
            ptb_pkg::ST_SCAN: begin
                state_next = more ? ptb_pkg::ST_SCAN : ptb_pkg::ST_IDLE;
                idx_next = idx_reg + 1'b1;
                case (mode_reg) inside
                    ptb_pkg::MODE_TICK: begin
                        if (fire) begin
                            idx_next = idx_reg;
                            if (per_mem[ix] == '0) begin
                                wr_last = 1'b1;
                                state_next = ptb_pkg::ST_WRITE;
                            end else begin
                                dreq.start = 1'b1;
                                state_next = ptb_pkg::ST_DIV;
                            end
                        end else if (!more && pend_reg) begin
                            kind_next = ptb_pkg::KIND_FIRED;
                            oslot_next = pslot_reg;
                            oname_next = pname_reg;
                            olast_next = 1'b1;
                            pend_next = 1'b0;
                            state_next = ptb_pkg::ST_OUT;
                        end
                    end
                    ptb_pkg::MODE_ADD: begin
                        wr_add = any_free;
                        if (any_free) vld_next[free_ix] = 1'b1;
                        kind_next = any_free ? ptb_pkg::KIND_ADDED : ptb_pkg::KIND_FULL;
                        oslot_next = any_free ? free_ix : '0;
                        oname_next = name_reg;
                        olast_next = 1'b1;
                        state_next = ptb_pkg::ST_ADD_OUT;
                    end
                    ptb_pkg::MODE_START, ptb_pkg::MODE_STOP: begin
                        if (nmatch) begin
                            wr_run = 1'b1;
                            wr_last = (mode_reg == ptb_pkg::MODE_START);
                        end
                    end
                    ptb_pkg::MODE_DELETE: if (nmatch) vld_next[ix] = 1'b0;
                    ptb_pkg::MODE_WAIT: wr_wait_set = smatch;
                    ptb_pkg::MODE_NOTIFY: wr_wait_clr = smatch;
                    ptb_pkg::MODE_CLR_SCENE: if (smatch) vld_next[ix] = 1'b0;
                    ptb_pkg::MODE_CLR_ALL: begin
                        vld_next = '0;
                        state_next = ptb_pkg::ST_IDLE;
                    end
                    default: state_next = ptb_pkg::ST_IDLE;
                endcase
            end
            ptb_pkg::ST_DIV: begin
                if (drsp.done) begin
                    wr_last = 1'b1;
                    wr_last_val = {1'b0, now_reg} - {32'd0, drsp.rem};
                    state_next = ptb_pkg::ST_WRITE;
                end
            end
            ptb_pkg::ST_WRITE: begin
                // previous fired slot goes out now, this one waits
                idx_next = idx_reg + 1'b1;
                pslot_next = ix;
                pname_next = name_mem[ix];
                pend_next = 1'b1;
                if (pend_reg) begin
                    kind_next = ptb_pkg::KIND_FIRED;
                    oslot_next = pslot_reg;
                    oname_next = pname_reg;
                    olast_next = 1'b0;
                    state_next = ptb_pkg::ST_OUT;
                end else begin
                    state_next = more ? ptb_pkg::ST_SCAN : ptb_pkg::ST_OUT;
                    if (!more) begin
                        kind_next = ptb_pkg::KIND_FIRED;
                        oslot_next = ix;
                        oname_next = name_mem[ix];
                        olast_next = 1'b1;
                        pend_next = 1'b0;
                    end
                end
                if (pend_reg && !more) begin
                    pend_next = 1'b1;
                end
            end
            ptb_pkg::ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    if (olast_reg) begin
                        state_next = ptb_pkg::ST_IDLE;
                    end else if (idx_reg == (SW+1)'(ptb_pkg::SLOTS)) begin
                        kind_next = ptb_pkg::KIND_FIRED;
                        oslot_next = pslot_reg;
                        oname_next = pname_reg;
                        olast_next = 1'b1;
                        pend_next = 1'b0;
                    end else begin
                        state_next = ptb_pkg::ST_SCAN;
                    end
                end
            end
            ptb_pkg::ST_ADD_OUT: begin
                out_valid = 1'b1;
                if (out_ready) state_next = ptb_pkg::ST_IDLE;
            end
            default: state_next = ptb_pkg::ST_IDLE;
        endcase
    end

    assign kind = kind_reg;
    assign slot = oslot_reg;
    assign fired_name = oname_reg;
    assign last = olast_reg;

    `include "periodic_timer_bank_assert.svh"
    `PTB_ASSERT_IMPL(a_ready_idle, ready, state_reg == ptb_pkg::ST_IDLE)
    `PTB_ASSERT_IMPL(a_div_only_in_div, drsp.busy, state_reg == ptb_pkg::ST_DIV)
    `PTB_ASSERT_NEXT(a_hold_stall, out_valid && !out_ready,
        out_valid && $stable(slot) && $stable(fired_name) && $stable(last))
    `PTB_ASSERT_NEXT(a_last_ends, out_valid && out_ready && last,
        state_reg == ptb_pkg::ST_IDLE)
endmodule
`default_nettype wire

/* rtl/ptb_mod_unit.sv */
`default_nettype none
module ptb_mod_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire ptb_pkg::div_req_t req,
    output ptb_pkg::div_rsp_t rsp
);
    localparam int CNT_W = $clog2(ptb_pkg::NOW_W + 1);

    logic [ptb_pkg::NOW_W-1:0] dvd_reg, dvd_next;
    logic [ptb_pkg::PER_W:0] rem_reg, rem_next;
    logic [ptb_pkg::PER_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [ptb_pkg::PER_W:0] trial;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    always_comb begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[ptb_pkg::PER_W-1:0], dvd_reg[ptb_pkg::NOW_W-1]};
        if (req.start) begin
            dvd_next = req.dividend;
            dvs_next = req.divisor;
            rem_next = '0;
            cnt_next = CNT_W'(ptb_pkg::NOW_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[ptb_pkg::NOW_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = trial - {1'b0, dvs_reg};
            end else begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.rem = rem_reg[ptb_pkg::PER_W-1:0];
endmodule
`default_nettype wire
